// ===== design/s256c_pkg.sv =====
`timescale 1ns / 1ps

package s256c_pkg;

  localparam int WORD_W      = 32;
  localparam int NUM_ROUNDS  = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int WIDX_W      = 4;   // word position inside a block
  localparam int RND_W       = 7;   // counts 0..NUM_ROUNDS
  localparam int RIDX_W      = 6;   // round index for the constant table
  localparam int CNT_W       = 16;  // block counter
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_REGS-1:0][WORD_W-1:0] hash_t;

  // standard initial hash, element 0 is H0
  localparam hash_t STD_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic ACT_WORD   = 1'b0;
  localparam logic ACT_RELOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_ROUND,
    ST_FINAL
  } state_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic              load_word;
    logic              reload;
    logic              sched_en;
    logic              init_wv;
    logic              round_en;
    logic              finalize;
    logic [RIDX_W-1:0] rnd;
  } dp_cmd_t;

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t f_ch(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t f_maj(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t round_k(input logic [RIDX_W-1:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== design/s256c_if.sv =====
`timescale 1ns / 1ps

interface s256c_in_if;
  import s256c_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  word_t msg_word;

  modport source (output valid, output action, output msg_word, input ready);
  modport sink   (input valid, input action, input msg_word, output ready);
endinterface

interface s256c_out_if;
  import s256c_pkg::*;

  logic             valid;
  logic             ready;
  word_t            hash_w0;
  word_t            hash_w1;
  word_t            hash_w2;
  word_t            hash_w3;
  word_t            hash_w4;
  word_t            hash_w5;
  word_t            hash_w6;
  word_t            hash_w7;
  logic [CNT_W-1:0] blocks_done;

  modport source (
    output valid, input ready,
    output hash_w0, output hash_w1, output hash_w2, output hash_w3,
    output hash_w4, output hash_w5, output hash_w6, output hash_w7,
    output blocks_done
  );
  modport sink (
    input valid, output ready,
    input hash_w0, input hash_w1, input hash_w2, input hash_w3,
    input hash_w4, input hash_w5, input hash_w6, input hash_w7,
    input blocks_done
  );
endinterface

// ===== design/s256c_cfg.sv =====
`timescale 1ns / 1ps

module s256c_cfg
  import s256c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready,
  output hash_t             init_h
);

  hash_t                 init_r;
  hash_t                 init_nxt;
  logic [REG_IDX_W-1:0]  reg_idx;

  // word-aligned register select
  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = init_r[reg_idx];
  assign init_h  = init_r;

  // write on the access phase
  always_comb begin
    init_nxt = init_r;
    if (psel && penable && pwrite) begin
      init_nxt[reg_idx] = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= STD_IV;
    end else begin
      init_r <= init_nxt;
    end
  end

endmodule

// ===== design/s256c_ctrl.sv =====
`timescale 1ns / 1ps

module s256c_ctrl
  import s256c_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_action,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic [RND_W-1:0]  RND_LAST = RND_W'(NUM_ROUNDS);
  localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(BLOCK_WORDS - 1);

  state_t            state_r, state_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              in_acc;

  assign in_ready  = (state_r == ST_FILL);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FILL;
      widx_r    <= '0;
      rnd_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      widx_r    <= widx_nxt;
      rnd_r     <= rnd_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    widx_nxt  = widx_r;
    rnd_nxt   = rnd_r;
    cmd       = '0;
    cmd.rnd   = rnd_r[RIDX_W-1:0];
    // drop the held result once taken
    out_vld_nxt = out_vld_r && !out_ready;

    case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (in_action == ACT_RELOAD) begin
            cmd.reload = 1'b1;
            widx_nxt   = '0;
          end else begin
            cmd.load_word = 1'b1;
            widx_nxt      = widx_r + 1'b1;
            if (widx_r == WIDX_LAST) begin
              rnd_nxt   = '0;
              state_nxt = ST_ROUND;
            end
          end
        end
      end
      ST_ROUND: begin
        // schedule runs one round ahead of the compression round
        cmd.sched_en = (rnd_r != RND_LAST);
        cmd.init_wv  = (rnd_r == '0);
        cmd.round_en = (rnd_r != '0);
        rnd_nxt      = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        // wait for a free output register
        if (!out_vld_r || out_ready) begin
          cmd.finalize = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

endmodule

// ===== design/s256c_dp.sv =====
`timescale 1ns / 1ps

module s256c_dp
  import s256c_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  word_t            msg_word,
  input  hash_t            init_h,
  output hash_t            hash_o,
  output logic [CNT_W-1:0] blocks_o
);

  word_t            win_r [BLOCK_WORDS];
  word_t            win_nxt [BLOCK_WORDS];
  word_t            wk_r, wk_nxt;
  hash_t            chain_r, chain_nxt;
  hash_t            wv_r, wv_nxt;
  hash_t            sum;
  hash_t            out_r;
  logic [CNT_W-1:0] blk_r, blk_nxt;
  logic [CNT_W-1:0] out_blk_r;
  word_t            w_t;
  word_t            t1, t2;

  // next schedule word: window holds W[t-16..t-1], oldest at entry 0
  always_comb begin
    if (cmd.rnd[RIDX_W-1:4] == '0) begin
      w_t = win_r[0];
    end else begin
      w_t = ssig1(win_r[14]) + win_r[9] + ssig0(win_r[1]) + win_r[0];
    end
  end

  // shift the window on a new message word or a schedule step
  always_comb begin
    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[BLOCK_WORDS-1] = cmd.load_word ? msg_word : w_t;
    wk_nxt = cmd.sched_en ? (w_t + round_k(cmd.rnd)) : wk_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.sched_en) begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
    wk_r <= wk_nxt;
  end

  // one compression round
  assign t1 = wv_r[7] + bsig1(wv_r[4]) + f_ch(wv_r[4], wv_r[5], wv_r[6]) + wk_r;
  assign t2 = bsig0(wv_r[0]) + f_maj(wv_r[0], wv_r[1], wv_r[2]);

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      sum[i] = chain_r[i] + wv_r[i];
    end
  end

  always_comb begin
    wv_nxt    = wv_r;
    chain_nxt = chain_r;
    blk_nxt   = blk_r;
    if (cmd.reload) begin
      chain_nxt = init_h;
      wv_nxt    = '0;
      blk_nxt   = '0;
    end else if (cmd.init_wv) begin
      wv_nxt = chain_r;
    end else if (cmd.round_en) begin
      wv_nxt[7] = wv_r[6];
      wv_nxt[6] = wv_r[5];
      wv_nxt[5] = wv_r[4];
      wv_nxt[4] = wv_r[3] + t1;
      wv_nxt[3] = wv_r[2];
      wv_nxt[2] = wv_r[1];
      wv_nxt[1] = wv_r[0];
      wv_nxt[0] = t1 + t2;
    end else if (cmd.finalize) begin
      chain_nxt = sum;
      blk_nxt   = blk_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= STD_IV;
      wv_r    <= '0;
      blk_r   <= '0;
    end else begin
      chain_r <= chain_nxt;
      wv_r    <= wv_nxt;
      blk_r   <= blk_nxt;
    end
  end

  // result register, loaded once per block
  always_ff @(posedge clk) begin
    if (cmd.finalize) begin
      out_r     <= sum;
      out_blk_r <= blk_r + 1'b1;
    end
  end

  assign hash_o   = out_r;
  assign blocks_o = out_blk_r;

endmodule

// ===== design/sha256_block_compress_unit.sv =====
`timescale 1ns / 1ps
// SHA-256 block compression unit.
// Input channel (in_ch): one word per handshake. action = 0 carries a 32-bit
// big-endian message word; action = 1 reloads the chaining value from the
// init_h0..init_h7 registers, clears the block counter and drops any partly
// filled block. Message words are taken one per cycle while filling.
// After the sixteenth word of a block the unit runs the 64 rounds, one per
// cycle, with the message schedule one round ahead; in_ch.ready stays low
// through the round/schedule steps and one final add. The result word
// (eight hash words plus a wrapping 16-bit block count) is valid on out_ch
// in the cycle after the final add; the single round unit sets the cost of
// each block, and no new message word is taken until it is done.
// The result sits in an output register: the next block is filled while it
// waits. If the receiver still stalls when the next block finishes, the unit
// holds in the final-add step until the register frees.
// Reset (rst_n low, synchronous) loads the standard initial hash into the
// chaining value and the init registers and clears all counters.
// The APB port writes init_h<i> at byte address 4*i; reads return it.

module sha256_block_compress_unit
  import s256c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  s256c_in_if.sink          in_ch,
  s256c_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  hash_t            init_h;
  hash_t            hash;
  logic [CNT_W-1:0] blocks;
  dp_cmd_t          cmd;

  s256c_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .init_h  (init_h)
  );

  s256c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  s256c_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .msg_word (in_ch.msg_word),
    .init_h   (init_h),
    .hash_o   (hash),
    .blocks_o (blocks)
  );

  assign out_ch.hash_w0     = hash[0];
  assign out_ch.hash_w1     = hash[1];
  assign out_ch.hash_w2     = hash[2];
  assign out_ch.hash_w3     = hash[3];
  assign out_ch.hash_w4     = hash[4];
  assign out_ch.hash_w5     = hash[5];
  assign out_ch.hash_w6     = hash[6];
  assign out_ch.hash_w7     = hash[7];
  assign out_ch.blocks_done = blocks;

endmodule

// ===== design/s256c_chk.sv =====
`timescale 1ns / 1ps

module s256c_chk
  import s256c_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CNT_W-1:0] out_blocks_done
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blocks_done))
    else $error("result dropped or changed while stalled");

  // a new result only appears after a busy compression
  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a compression");

  // returning to fill always leaves a result behind
  a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid)
    else $error("compression finished without a result");

  // compression never lasts a single cycle
  a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |=> !in_ready)
    else $error("input reopened too early");

endmodule

bind sha256_block_compress_unit s256c_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_blocks_done (out_ch.blocks_done)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import s256c_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_WORDS  = 385;

  // round constants of the compression function
  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // corner words for the directed block
  localparam word_t EDGE_WORDS [16] = '{
    32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
    32'h7fffffff, 32'hfffffffe, 32'haaaaaaaa, 32'h55555555,
    32'h61626380, 32'h00000000, 32'hffffffff, 32'h0000ffff,
    32'hffff0000, 32'h01234567, 32'h89abcdef, 32'h00000018
  };

  typedef struct packed {
    logic [7:0][WORD_W-1:0] h;
    logic [CNT_W-1:0]       blocks;
  } digest_t;

  // tracks chaining value and block position; queues each finished digest
  class hash_tracker;
    word_t init_h [8];
    word_t chain [8];
    word_t window [16];
    logic [WIDX_W-1:0] widx;
    logic [CNT_W-1:0] nblocks;
    digest_t pending_digests [$];
    int errors;

    function new();
      for (int i = 0; i < 8; i++) begin
        init_h[i] = IV_TAB[i];
        chain[i] = IV_TAB[i];
      end
      widx = '0;
      nblocks = '0;
      errors = 0;
    endfunction

    function void set_init(int idx, word_t val);
      if (idx < NUM_REGS) begin
        init_h[idx] = val;
      end
    endfunction

    function word_t rotr(word_t v, int n);
      return (v >> n) | (v << (WORD_W - n));
    endfunction

    // run 64 rounds over the filled window and fold into the chain
    function void compress();
      word_t w [64];
      word_t v [8];
      word_t s0, s1, t1, t2;
      for (int t = 0; t < 16; t++) begin
        w[t] = window[t];
      end
      for (int t = 16; t < 64; t++) begin
        s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
        s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
        s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
        chain[i] = chain[i] + v[i];
      end
    endfunction

    function void note_word(logic act, word_t wd);
      digest_t d;
      if (act == ACT_RELOAD) begin
        chain = init_h;
        widx = '0;
        nblocks = '0;
        return;
      end
      window[widx] = wd;
      widx = widx + 1'b1;
      if (widx != 0) begin
        return;
      end
      compress();
      nblocks = nblocks + 1'b1;
      for (int i = 0; i < 8; i++) begin
        d.h[i] = chain[i];
      end
      d.blocks = nblocks;
      pending_digests.push_back(d);
    endfunction

    function void check_digest(digest_t got);
      digest_t want;
      if (pending_digests.size() == 0) begin
        $error("result word with no digest pending");
        errors++;
        return;
      end
      want = pending_digests.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (got.h[i] !== want.h[i]) begin
          $error("hash_w%0d: expected %08h, actual %08h", i, want.h[i], got.h[i]);
          errors++;
        end
      end
      if (got.blocks !== want.blocks) begin
        $error("blocks_done: expected %0d, actual %0d", want.blocks, got.blocks);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [WORD_W-1:0] pwdata, prdata;
  logic pready;
  bit in_quiet, out_quiet;
  hash_tracker book;

  s256c_in_if  in_ch ();
  s256c_out_if out_ch ();

  sha256_block_compress_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t rand_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      default: return $urandom();
    endcase
  endfunction

  // present one word and hold it until accepted
  task automatic send_item(logic act, word_t wd);
    int gap;
    gap = pick_gap(in_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.msg_word <= wd;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.note_word(act, wd);
  endtask

  task automatic reg_write(int idx, word_t val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    book.set_init(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(int idx);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(4 * idx);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== book.init_h[idx]) begin
      $error("init_h%0d: expected %08h, actual %08h", idx, book.init_h[idx], prdata);
      book.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // drop valid, wait for every digest, then let the engine go quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (book.pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 63) == 0) begin
        send_item(ACT_RELOAD, $urandom());
      end else begin
        send_item(ACT_WORD, rand_word());
      end
    end
  endtask

  // receiver: stall at random unless in a quiet stretch
  initial begin
    int len;
    out_ch.ready = 1'b0;
    forever begin
      if (out_quiet) begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end else begin
        len = pick_gap(1'b0);
        if (len > 0) begin
          out_ch.ready <= 1'b0;
          repeat (len) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  // check every accepted result word
  always @(posedge clk) begin : result_mon
    digest_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.h[0] = out_ch.hash_w0;
      got.h[1] = out_ch.hash_w1;
      got.h[2] = out_ch.hash_w2;
      got.h[3] = out_ch.hash_w3;
      got.h[4] = out_ch.hash_w4;
      got.h[5] = out_ch.hash_w5;
      got.h[6] = out_ch.hash_w6;
      got.h[7] = out_ch.hash_w7;
      got.blocks = out_ch.blocks_done;
      book.check_digest(got);
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    word_t val;
    book = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WORD;
    in_ch.msg_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers come up holding the standard initial hash
    for (int i = 0; i < NUM_REGS; i++) begin
      reg_read(i);
    end

    // one block of corner words, a discarded partial block, back-to-back reloads
    for (int i = 0; i < 16; i++) begin
      send_item(ACT_WORD, EDGE_WORDS[i]);
    end
    for (int i = 0; i < 5; i++) begin
      send_item(ACT_WORD, EDGE_WORDS[15 - i]);
    end
    send_item(ACT_RELOAD, '1);
    send_item(ACT_RELOAD, '0);
    random_phase(PHASE_WORDS);

    // zeros, ones, random, then back to the standard hash
    for (int p = 1; p < 5; p++) begin
      settle();
      in_quiet = (p == 2);
      out_quiet = (p == 3);
      for (int i = 0; i < NUM_REGS; i++) begin
        case (p)
          1: val = '0;
          2: val = '1;
          3: val = $urandom();
          default: val = IV_TAB[i];
        endcase
        reg_write(i, val);
      end
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_read(i);
      end
      send_item(ACT_RELOAD, rand_word());
      random_phase(PHASE_WORDS);
    end

    settle();
    if (book.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
